FILE: sv/pdwt_pkg.sv
// Shared constants, register indexes and types of the pulse-distance word transmitter.
`default_nettype none
package pdwt_pkg;

  // Number of data bits sent in one frame, most significant bit first.
  localparam int DATA_BITS = 16;
  localparam int WORD_W    = 16;
  localparam int TICK_W    = 16;

  // Configuration registers.
  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = $clog2(NUM_REGS + 1);

  localparam logic [REG_IDX_W-1:0] R_LEAD  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] R_HLOW  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] R_HHIGH = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] R_BLOW  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] R_ZHIGH = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] R_OHIGH = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] R_SHIGH = REG_IDX_W'(6);

  localparam logic [TICK_W-1:0] LEAD_RST  = TICK_W'(250);
  localparam logic [TICK_W-1:0] HLOW_RST  = TICK_W'(1000);
  localparam logic [TICK_W-1:0] HHIGH_RST = TICK_W'(700);
  localparam logic [TICK_W-1:0] BLOW_RST  = TICK_W'(250);
  localparam logic [TICK_W-1:0] ZHIGH_RST = TICK_W'(750);
  localparam logic [TICK_W-1:0] OHIGH_RST = TICK_W'(1750);
  localparam logic [TICK_W-1:0] SHIGH_RST = TICK_W'(1750);

  // Frame phases: lead, header low, header high, a low and a high per bit,
  // stop low and stop high.
  localparam int PH_LAST_BIT_I   = 2 + 2 * DATA_BITS;
  localparam int PH_STOP_HIGH_I  = PH_LAST_BIT_I + 2;
  localparam int PHASE_W         = $clog2(PH_STOP_HIGH_I + 1);

  localparam logic [PHASE_W-1:0] PH_LEAD      = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_HLOW      = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_HHIGH     = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PH_FIRST_BIT = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] PH_LAST_BIT  = PHASE_W'(PH_LAST_BIT_I);
  localparam logic [PHASE_W-1:0] PH_STOP_LOW  = PHASE_W'(PH_LAST_BIT_I + 1);
  localparam logic [PHASE_W-1:0] PH_STOP_HIGH = PHASE_W'(PH_STOP_HIGH_I);

  // Input operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  typedef logic [NUM_REGS-1:0][TICK_W-1:0] cfg_regs_t;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase_index;
    logic [TICK_W-1:0]    ticks_left;
    logic [DATA_BITS-1:0] shift_word;
    logic                 sending;
    logic                 level;
  } tx_state_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
    logic frame_done;
  } tx_result_t;

endpackage
`default_nettype wire

FILE: sv/pdwt_step.sv
// Next-state and result logic of the transmitter for one input item.
`default_nettype none
module pdwt_step
  import pdwt_pkg::*;
(
  input  wire tx_state_t         st,
  input  wire cfg_regs_t         cfg,
  input  wire logic              opcode,
  input  wire logic [WORD_W-1:0] data_word,
  output tx_state_t              st_nxt,
  output tx_result_t             res
);

  logic [PHASE_W-1:0] next_phase;
  logic               rej;
  logic               done;

  assign next_phase = PHASE_W'(st.phase_index + 1'b1);

  always_comb begin
    st_nxt = st;
    rej    = 1'b0;
    done   = 1'b0;
    if (opcode == OP_SEND) begin
      if (st.sending) begin
        rej = 1'b1;
      end else begin
        st_nxt.sending     = 1'b1;
        st_nxt.shift_word  = DATA_BITS'(data_word);
        st_nxt.phase_index = PH_LEAD;
        st_nxt.level       = 1'b1;
        st_nxt.ticks_left  = cfg[R_LEAD];
      end
    end else if (st.sending) begin
      if (st.ticks_left <= TICK_W'(1)) begin
        if (st.phase_index >= PH_STOP_HIGH) begin
          st_nxt.sending     = 1'b0;
          st_nxt.level       = 1'b1;
          st_nxt.ticks_left  = '0;
          st_nxt.phase_index = PH_LEAD;
          done               = 1'b1;
        end else begin
          st_nxt.phase_index = next_phase;
          priority if (next_phase == PH_HLOW) begin
            st_nxt.level      = 1'b0;
            st_nxt.ticks_left = cfg[R_HLOW];
          end else if (next_phase == PH_HHIGH) begin
            st_nxt.level      = 1'b1;
            st_nxt.ticks_left = cfg[R_HHIGH];
          end else if (next_phase >= PH_FIRST_BIT && next_phase <= PH_LAST_BIT) begin
            // Bit phases start at an odd index: odd is the low, even the high.
            if (next_phase[0]) begin
              st_nxt.level      = 1'b0;
              st_nxt.ticks_left = cfg[R_BLOW];
            end else begin
              st_nxt.level      = 1'b1;
              st_nxt.ticks_left = st.shift_word[DATA_BITS-1] ? cfg[R_OHIGH] : cfg[R_ZHIGH];
              st_nxt.shift_word = st.shift_word << 1;
            end
          end else if (next_phase == PH_STOP_LOW) begin
            st_nxt.level      = 1'b0;
            st_nxt.ticks_left = cfg[R_BLOW];
          end else begin
            st_nxt.level      = 1'b1;
            st_nxt.ticks_left = cfg[R_SHIGH];
          end
        end
      end else begin
        st_nxt.ticks_left = st.ticks_left - 1'b1;
      end
    end
  end

  assign res.line_level = st_nxt.level;
  assign res.busy_res   = st_nxt.sending;
  assign res.rejected   = rej;
  assign res.frame_done = done;

endmodule
`default_nettype wire

FILE: sv/pulse_distance_word_transmitter_unit.sv
// Top level of the pulse-distance word transmitter: channels, registers and frame state.
`default_nettype none
// The unit sends a 16-bit word, most significant bit first, on one line as a
// pulse-distance frame: a lead high, a header low and high, then for every bit a
// fixed low followed by a short high (zero) or a long high (one), and finally a stop
// low and a stop high, after which the line idles high again. Every input item is
// either one time tick (opcode 0) or a request to send data_word (opcode 1); each
// item yields exactly one result item carrying the line level, the busy flag, a
// flag for a send request dropped because a frame was already in progress, and a
// flag on the tick that ends the stop high period. All period lengths are tick
// counts held in seven configuration registers, written through cfg_we, cfg_index
// and cfg_wdata; indexes beyond the last register are ignored, and a value of zero
// behaves as one tick. The unit takes one item every clock cycle while results are
// taken: an item is held in an input register, the frame state and result are
// worked out in one pass of logic, and the result is loaded into the output
// register once that register is empty or being read. While a result waits, the
// input register can still take one more item; after that the input side stalls
// until the waiting result is taken.
module pulse_distance_word_transmitter_unit
  import pdwt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_opcode,
  input  wire logic [WORD_W-1:0]    in_data_word,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_line_level,
  output logic                      out_busy_res,
  output logic                      out_rejected,
  output logic                      out_frame_done,
  // Configuration port
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [TICK_W-1:0]    cfg_wdata
);

  // Configuration registers.
  cfg_regs_t cfg_r;

  // Input register.
  logic              in_valid_r;
  logic              in_opcode_r;
  logic [WORD_W-1:0] in_data_word_r;

  // Frame state and result register.
  tx_state_t  st_r;
  tx_state_t  st_nxt;
  tx_result_t res_nxt;
  tx_result_t res_r;
  logic       out_valid_r;

  logic out_free;
  logic advance;

  // The output register can take a new result when it is empty or being read.
  assign out_free = !out_valid_r || out_ready;
  // An item moves from the input register into the frame state this cycle.
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[R_LEAD]  <= LEAD_RST;
      cfg_r[R_HLOW]  <= HLOW_RST;
      cfg_r[R_HHIGH] <= HHIGH_RST;
      cfg_r[R_BLOW]  <= BLOW_RST;
      cfg_r[R_ZHIGH] <= ZHIGH_RST;
      cfg_r[R_OHIGH] <= OHIGH_RST;
      cfg_r[R_SHIGH] <= SHIGH_RST;
    end else if (cfg_we && cfg_index < REG_IDX_W'(NUM_REGS)) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_opcode_r    <= in_opcode;
      in_data_word_r <= in_data_word;
    end
  end

  pdwt_step u_step (
    .st        (st_r),
    .cfg       (cfg_r),
    .opcode    (in_opcode_r),
    .data_word (in_data_word_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase_index <= PH_LEAD;
      st_r.ticks_left  <= '0;
      st_r.shift_word  <= '0;
      st_r.sending     <= 1'b0;
      st_r.level       <= 1'b1;
      out_valid_r      <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = res_r.line_level;
  assign out_busy_res   = res_r.busy_res;
  assign out_rejected   = res_r.rejected;
  assign out_frame_done = res_r.frame_done;

  // The line is high whenever no frame is in progress.
  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.sending |-> st_r.level)
    else $error("line low while idle");

  // The phase never runs past the stop high period.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase_index <= PH_STOP_HIGH)
    else $error("phase index out of range");

  // A finished frame leaves the unit idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_busy_res && out_line_level)
    else $error("frame done while still busy");

  // A dropped request and the end of a frame come from different item kinds.
  a_rej_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_frame_done && out_busy_res)
    else $error("rejection inconsistent with state");

  // A waiting result is not overwritten by a new item.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r))
    else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench of the pulse-distance word transmitter unit.
`timescale 1ns / 1ps

// The bench sends a stream of tick and send items, predicts the line level and the
// status flags that each item must produce, and compares every result item with the
// oldest prediction.
//
// The prediction is a behavioural copy of the frame sequencer. It keeps its own
// shadow of the seven period registers, and it is advanced at the moment an item is
// accepted. Register writes only happen once the result queue has drained, so the
// order in which the shadow and the unit see writes and items is the same.
module tb;
  import pdwt_pkg::*;

  // Clock, reset and the ports of the unit. Every input has a known value from the
  // first instant of the run.
  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic                 in_opcode    = OP_TICK;
  logic [WORD_W-1:0]    in_data_word = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic                 out_line_level;
  logic                 out_busy_res;
  logic                 out_rejected;
  logic                 out_frame_done;
  logic                 cfg_we       = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index    = '0;
  logic [TICK_W-1:0]    cfg_wdata    = '0;

  pulse_distance_word_transmitter_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_data_word  (in_data_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_line_level(out_line_level),
    .out_busy_res  (out_busy_res),
    .out_rejected  (out_rejected),
    .out_frame_done(out_frame_done),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // 12 ns clock period.
  always #6 clk = ~clk;

  // Shadow of the period registers and of the frame sequencer state.
  logic [TICK_W-1:0]    period_regs [NUM_REGS];
  logic [PHASE_W-1:0]   line_phase;
  logic [TICK_W-1:0]    line_ticks;
  logic [DATA_BITS-1:0] line_shift;
  logic                 line_busy;
  logic                 line_level;

  // Predicted result items, oldest first.
  tx_result_t line_results_q [$];

  // When clear, neither side inserts gaps or stalls.
  bit gaps_on = 1'b1;

  int error_count  = 0;
  int items_sent   = 0;
  int frames_seen  = 0;
  int rejects_seen = 0;
  int writes_done  = 0;

  // The run is ended here if the normal end is never reached.
  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $display("Timed out with %0d results still outstanding.", line_results_q.size());
    $finish;
  end

  // Puts the shadow into its state after reset.
  function automatic void reset_line_model();
    period_regs[R_LEAD]  = LEAD_RST;
    period_regs[R_HLOW]  = HLOW_RST;
    period_regs[R_HHIGH] = HHIGH_RST;
    period_regs[R_BLOW]  = BLOW_RST;
    period_regs[R_ZHIGH] = ZHIGH_RST;
    period_regs[R_OHIGH] = OHIGH_RST;
    period_regs[R_SHIGH] = SHIGH_RST;
    line_phase = PH_LEAD;
    line_ticks = '0;
    line_shift = '0;
    line_busy  = 1'b0;
    line_level = 1'b1;
  endfunction

  // Advances the shadow sequencer by one item and returns the result it must give.
  // A period of N ticks ends on its N-th tick, and the next period is loaded on that
  // same tick; a period register of zero therefore behaves as one.
  function automatic tx_result_t frame_step(logic op, logic [WORD_W-1:0] word);
    tx_result_t           r;
    logic [PHASE_W-1:0]   nxt;
    logic [PHASE_W-1:0]   rel;
    r.rejected   = 1'b0;
    r.frame_done = 1'b0;
    if (op == OP_SEND) begin
      if (line_busy) begin
        // A send request during a frame is dropped and leaves the state alone.
        r.rejected = 1'b1;
      end else begin
        line_busy  = 1'b1;
        line_shift = word;
        line_phase = PH_LEAD;
        line_level = 1'b1;
        line_ticks = period_regs[R_LEAD];
      end
    end else if (line_busy) begin
      if (line_ticks <= 1) begin
        if (line_phase >= PH_STOP_HIGH) begin
          line_busy    = 1'b0;
          line_level   = 1'b1;
          line_ticks   = '0;
          line_phase   = PH_LEAD;
          r.frame_done = 1'b1;
        end else begin
          nxt        = line_phase + 1'b1;
          line_phase = nxt;
          rel        = nxt - PH_FIRST_BIT;
          if (nxt == PH_HLOW) begin
            line_level = 1'b0;
            line_ticks = period_regs[R_HLOW];
          end else if (nxt == PH_HHIGH) begin
            line_level = 1'b1;
            line_ticks = period_regs[R_HHIGH];
          end else if (nxt >= PH_FIRST_BIT && nxt <= PH_LAST_BIT) begin
            if (!rel[0]) begin
              line_level = 1'b0;
              line_ticks = period_regs[R_BLOW];
            end else begin
              // The high half of a bit: its length is set by the current top bit.
              line_level = 1'b1;
              line_ticks = line_shift[DATA_BITS-1] ? period_regs[R_OHIGH]
                                                   : period_regs[R_ZHIGH];
              line_shift = line_shift << 1;
            end
          end else if (nxt == PH_STOP_LOW) begin
            line_level = 1'b0;
            line_ticks = period_regs[R_BLOW];
          end else begin
            line_level = 1'b1;
            line_ticks = period_regs[R_SHIGH];
          end
        end
      end else begin
        line_ticks = line_ticks - 1'b1;
      end
    end
    // A tick while idle changes nothing: the line stays high.
    r.line_level = line_level;
    r.busy_res   = line_busy;
    return r;
  endfunction

  // Length of a gap or a stall: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A period value for the random phases: short, so that frames stay brief, with
  // zero among them.
  function automatic logic [TICK_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 80) return TICK_W'($urandom_range(1, 3));
    if (r < 95) return TICK_W'($urandom_range(4, 8));
    return TICK_W'($urandom_range(9, 20));
  endfunction

  // Sends one item. It is entered and left just after a falling edge; valid is left
  // high on return, so that the next call either lowers it for a gap or puts the next
  // item on the port straight away, never both in one step.
  task automatic send_item(logic op, logic [WORD_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_data_word <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    line_results_q.push_back(frame_step(op, word));
    items_sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted result has been taken, and then lets
  // the clock run on so that the unit holds nothing in flight.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (line_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register. The unit must be idle; write enable is lowered for a whole
  // cycle between two writes.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    // Indexes past the last register are ignored by the unit.
    if (idx < NUM_REGS) period_regs[idx] = val;
    writes_done++;
    @(negedge clk);
  endtask

  // Keeps ticking until the predicted frame has ended.
  task automatic tick_until_idle();
    while (line_busy) send_item(OP_TICK, WORD_W'($urandom));
  endtask

  // Reset values: a send with the reset periods, ticked to the last tick of the lead.
  // The registers are then rewritten mid-frame; the lead that was already loaded
  // keeps its old length and the new values apply from the header low on.
  task automatic test_reset_periods();
    send_item(OP_TICK, 16'hFFFF);
    send_item(OP_TICK, 16'h0000);
    send_item(OP_SEND, 16'hA53C);
    repeat (LEAD_RST - 1) send_item(OP_TICK, WORD_W'($urandom));
    wait_results_drained();
    write_reg(R_LEAD,  16'd1);
    write_reg(R_HLOW,  16'd2);
    write_reg(R_HHIGH, 16'd1);
    write_reg(R_BLOW,  16'd1);
    write_reg(R_ZHIGH, 16'd1);
    write_reg(R_OHIGH, 16'd2);
    write_reg(R_SHIGH, 16'd1);
    tick_until_idle();
  endtask

  // All ones and all zeros words, a send refused while busy, and a new send on the
  // item straight after the one that ends a frame.
  task automatic test_word_extremes();
    wait_results_drained();
    write_reg(R_LEAD,  16'd2);
    write_reg(R_HLOW,  16'd1);
    write_reg(R_HHIGH, 16'd3);
    write_reg(R_BLOW,  16'd1);
    write_reg(R_ZHIGH, 16'd1);
    write_reg(R_OHIGH, 16'd2);
    write_reg(R_SHIGH, 16'd2);
    send_item(OP_SEND, 16'hFFFF);
    send_item(OP_SEND, 16'h1234);
    send_item(OP_TICK, 16'h0000);
    tick_until_idle();
    send_item(OP_SEND, 16'h0000);
    repeat (5) send_item(OP_TICK, 16'hFFFF);
    send_item(OP_SEND, 16'hFFFF);
    tick_until_idle();
    send_item(OP_SEND, 16'h8001);
    tick_until_idle();
    send_item(OP_TICK, 16'h5555);
  endtask

  // Every period register at zero, which must act as one tick.
  task automatic test_zero_periods();
    wait_results_drained();
    for (int i = 0; i < NUM_REGS; i++) write_reg(REG_IDX_W'(i), '0);
    send_item(OP_SEND, 16'h5A5A);
    tick_until_idle();
  endtask

  // Writes to the one index beyond the last register, with a value that would stretch
  // the frame enormously if it were taken.
  task automatic test_unused_index();
    wait_results_drained();
    for (int i = NUM_REGS; i < (1 << REG_IDX_W); i++) write_reg(REG_IDX_W'(i), 16'hFFFF);
    send_item(OP_SEND, 16'h00FF);
    tick_until_idle();
  endtask

  // Random traffic in several register settings. While a frame runs most items are
  // ticks with the odd refused send; when idle most items start a new frame. Each
  // setting is written with the queue drained, which often falls inside a frame.
  task automatic test_random_traffic();
    logic op;
    for (int ph = 0; ph < 5; ph++) begin
      wait_results_drained();
      gaps_on = (ph != 2);
      for (int i = 0; i < NUM_REGS; i++) write_reg(REG_IDX_W'(i), pick_period());
      for (int n = 0; n < 60; n++) begin
        if (line_busy) op = ($urandom_range(0, 9) == 0) ? OP_SEND : OP_TICK;
        else op = ($urandom_range(0, 9) < 7) ? OP_SEND : OP_TICK;
        send_item(op, WORD_W'($urandom));
      end
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: ready with random stalls, changed at the falling edge.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!gaps_on) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  function automatic void compare_bit(string name, logic want, logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Every result item taken at a rising edge is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    tx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (line_results_q.size() == 0) begin
        $display("%0t: result item with no item outstanding", $time);
        error_count++;
      end else begin
        want = line_results_q.pop_front();
        compare_bit("line_level", want.line_level, out_line_level);
        compare_bit("busy_res",   want.busy_res,   out_busy_res);
        compare_bit("rejected",   want.rejected,   out_rejected);
        compare_bit("frame_done", want.frame_done, out_frame_done);
      end
      if (out_frame_done === 1'b1) frames_seen++;
      if (out_rejected === 1'b1) rejects_seen++;
    end
  end

  initial begin
    reset_line_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_periods();
    test_word_extremes();
    test_zero_periods();
    test_unused_index();
    test_random_traffic();

    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d items over %0d register writes, with zero periods and changes mid-frame.",
             items_sent, writes_done);
    $display("Frames completed: %0d; send requests refused while busy: %0d.",
             frames_seen, rejects_seen);
    if (error_count == 0 && line_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
